FILE: rtl/pst_pkg.sv
package pst_pkg;

  localparam int TIMER_BITS_DEF = 27;
  localparam int CFG_W          = 27;
  localparam int TOD_W          = 27;
  localparam int REQ_W          = 3;
  localparam int MODE_W         = 3;
  localparam int CFG_IDX_W      = 3;

  localparam int DAY_MS            = 86400000;
  localparam int FILTER_WAIT_MS    = 2000;
  localparam int SOLAR_WAIT_MS     = 1000;
  localparam int SOLAR_FALLBACK_MS = 900000;

  localparam logic [CFG_W-1:0] RST_FILTER_ON_MS     = CFG_W'(3600000);
  localparam logic [CFG_W-1:0] RST_FILTER_PERIOD_MS = CFG_W'(14400000);
  localparam logic [CFG_W-1:0] RST_SOLAR_ON_MS      = CFG_W'(70000);
  localparam logic [CFG_W-1:0] RST_SOLAR_PERIOD_MS  = CFG_W'(900000);
  localparam logic [CFG_W-1:0] RST_DAY_START_MS     = CFG_W'(28800000);
  localparam logic [CFG_W-1:0] RST_NIGHT_START_MS   = CFG_W'(75600000);
  localparam logic [TOD_W-1:0] RST_TOD_MS           = TOD_W'(32400000);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_TICK        = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SET_TIME    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_FORCE_OFF   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_FORCE_ON    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FORCE_SOLAR = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ON     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_PERIOD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLAR_ON      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOLAR_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DAY_START     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NIGHT_START   = 3'd5;

  // Filter machine states.
  localparam logic [MODE_W-1:0] FM_INIT  = 3'd0;
  localparam logic [MODE_W-1:0] FM_WAIT  = 3'd1;
  localparam logic [MODE_W-1:0] FM_RUN   = 3'd2;
  localparam logic [MODE_W-1:0] FM_NIGHT = 3'd3;
  localparam logic [MODE_W-1:0] FM_FON   = 3'd4;
  localparam logic [MODE_W-1:0] FM_FOFF  = 3'd5;

  // Solar machine states.
  localparam logic [MODE_W-1:0] SM_INIT  = 3'd0;
  localparam logic [MODE_W-1:0] SM_WAIT  = 3'd1;
  localparam logic [MODE_W-1:0] SM_RUN   = 3'd2;
  localparam logic [MODE_W-1:0] SM_NIGHT = 3'd3;
  localparam logic [MODE_W-1:0] SM_FORCE = 3'd4;

  // Decoded request for the pump machines, qualified by the item moving on.
  typedef struct packed {
    logic tick;
    logic force_off;
    logic force_on;
    logic force_solar;
    logic night;
  } pst_ctl_t;

endpackage

FILE: rtl/pst_if.sv
interface pst_in_if import pst_pkg::*;;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [CFG_W-1:0]   value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface pst_out_if import pst_pkg::*;;
  logic               valid;
  logic               ready;
  logic               filter_relay;
  logic               solar_relay;
  logic               night_flag;
  logic [TOD_W-1:0]   time_of_day_ms;
  logic [MODE_W-1:0]  filter_mode;
  logic [MODE_W-1:0]  solar_mode;

  modport source (output valid, output filter_relay, output solar_relay, output night_flag,
                  output time_of_day_ms, output filter_mode, output solar_mode, input ready);
  modport sink   (input valid, input filter_relay, input solar_relay, input night_flag,
                  input time_of_day_ms, input filter_mode, input solar_mode, output ready);
endinterface

FILE: rtl/pst_clock.sv
module pst_clock import pst_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             set_time,
  input  logic [CFG_W-1:0] value,
  input  logic [CFG_W-1:0] day_start_ms,
  input  logic [CFG_W-1:0] night_start_ms,
  output logic             night_nxt,
  output logic [TOD_W-1:0] tod_nxt
);

  logic [TOD_W-1:0] tod_r;
  logic             night_r;
  logic [TOD_W:0]   tod_inc;

  assign tod_inc = {1'b0, tod_r} + (TOD_W+1)'(1);

  always_comb begin
    tod_nxt   = tod_r;
    night_nxt = night_r;
    if (tick) begin
      // A loaded time beyond one day wraps on the next tick as well.
      if (tod_inc >= (TOD_W+1)'(DAY_MS)) begin
        tod_nxt = '0;
      end else begin
        tod_nxt = tod_inc[TOD_W-1:0];
      end
      if (!night_r && (tod_nxt == night_start_ms)) begin
        night_nxt = 1'b1;
      end else if (night_r && (tod_nxt == day_start_ms)) begin
        night_nxt = 1'b0;
      end
    end else if (set_time) begin
      tod_nxt   = value;
      night_nxt = (value < day_start_ms) || (value > night_start_ms);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tod_r   <= RST_TOD_MS;
      night_r <= 1'b0;
    end else begin
      tod_r   <= tod_nxt;
      night_r <= night_nxt;
    end
  end

`ifndef SYNTHESIS
  a_tod_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    tick |=> (tod_r < TOD_W'(DAY_MS)))
    else $error("time of day beyond one day after a tick");
`endif

endmodule

FILE: rtl/pst_filter.sv
module pst_filter import pst_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pst_ctl_t          ctl,
  input  logic [CFG_W-1:0]  value,
  input  logic [CFG_W-1:0]  on_ms,
  input  logic [CFG_W-1:0]  period_ms,
  output logic              relay_nxt,
  output logic [MODE_W-1:0] mode_nxt
);

  localparam int TB = TIMER_BITS;

  logic [MODE_W-1:0] st_r, prev_r, st_nxt, prev_nxt;
  logic [TB-1:0]     cyc_r, cyc_nxt;
  logic [TB-1:0]     foff_r, foff_nxt;
  logic [TB-1:0]     fon_r, fon_nxt;
  logic [TB-1:0]     roff_r, roff_nxt;
  logic              drv_r, drv_nxt;
  logic              entry;

  assign entry = (st_r != prev_r);

  always_comb begin
    st_nxt   = st_r;
    prev_nxt = prev_r;
    cyc_nxt  = cyc_r;
    foff_nxt = foff_r;
    fon_nxt  = fon_r;
    roff_nxt = roff_r;
    drv_nxt  = drv_r;
    if (ctl.tick) begin
      // Counters advance first, then the machine looks at the new values.
      if (roff_r != '0) begin
        roff_nxt = roff_r - TB'(1);
        if (roff_r == TB'(1)) begin
          drv_nxt = 1'b0;
        end
      end
      cyc_nxt  = (cyc_r != '0) ? cyc_r - TB'(1) : '0;
      foff_nxt = (foff_r != '0) ? foff_r - TB'(1) : '0;
      fon_nxt  = (fon_r != '0) ? fon_r - TB'(1) : '0;
      prev_nxt = st_r;
      case (st_r)
        FM_INIT: begin
          st_nxt = FM_WAIT;
        end
        FM_WAIT: begin
          if (entry) begin
            cyc_nxt = TB'(FILTER_WAIT_MS);
          end
          if (cyc_nxt == '0) begin
            st_nxt = FM_RUN;
          end
        end
        FM_RUN: begin
          if (entry) begin
            cyc_nxt = '0;
          end
          if (cyc_nxt == '0) begin
            cyc_nxt = TB'(period_ms);
            drv_nxt = 1'b1;
            if (on_ms != '0) begin
              roff_nxt = TB'(on_ms);
            end
          end
          if (foff_nxt != '0) begin
            st_nxt = FM_FOFF;
          end else if (fon_nxt != '0) begin
            st_nxt = FM_FON;
          end else if (ctl.night) begin
            st_nxt = FM_NIGHT;
          end
        end
        FM_NIGHT: begin
          if (entry) begin
            drv_nxt = 1'b0;
          end
          if (foff_nxt != '0) begin
            st_nxt = FM_FOFF;
          end else if (fon_nxt != '0) begin
            st_nxt = FM_FON;
          end else if (!ctl.night) begin
            st_nxt = FM_RUN;
          end
        end
        FM_FON: begin
          if (entry) begin
            drv_nxt = 1'b1;
            if (fon_nxt != '0) begin
              roff_nxt = fon_nxt;
            end
          end
          if (fon_nxt == '0) begin
            st_nxt = ctl.night ? FM_NIGHT : FM_RUN;
          end
        end
        FM_FOFF: begin
          if (entry) begin
            drv_nxt = 1'b0;
          end
          if (foff_nxt == '0) begin
            st_nxt = ctl.night ? FM_NIGHT : FM_RUN;
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.force_off) begin
      foff_nxt = TB'(value);
      fon_nxt  = '0;
    end else if (ctl.force_on) begin
      fon_nxt  = TB'(value);
      foff_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FM_INIT;
      prev_r <= FM_INIT;
      cyc_r  <= '0;
      foff_r <= '0;
      fon_r  <= '0;
      roff_r <= '0;
      drv_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      cyc_r  <= cyc_nxt;
      foff_r <= foff_nxt;
      fon_r  <= fon_nxt;
      roff_r <= roff_nxt;
      drv_r  <= drv_nxt;
    end
  end

  assign relay_nxt = drv_nxt;
  assign mode_nxt  = st_nxt;

endmodule

FILE: rtl/pst_solar.sv
module pst_solar import pst_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pst_ctl_t          ctl,
  input  logic [CFG_W-1:0]  value,
  input  logic [CFG_W-1:0]  on_ms,
  input  logic [CFG_W-1:0]  period_ms,
  output logic              relay_nxt,
  output logic [MODE_W-1:0] mode_nxt
);

  localparam int TB = TIMER_BITS;

  logic [MODE_W-1:0] st_r, prev_r, st_nxt, prev_nxt;
  logic [TB-1:0]     cyc_r, cyc_nxt;
  logic [TB-1:0]     fsol_r, fsol_nxt;
  logic [TB-1:0]     roff_r, roff_nxt;
  logic              drv_r, drv_nxt;
  logic              entry;

  assign entry = (st_r != prev_r);

  always_comb begin
    st_nxt   = st_r;
    prev_nxt = prev_r;
    cyc_nxt  = cyc_r;
    fsol_nxt = fsol_r;
    roff_nxt = roff_r;
    drv_nxt  = drv_r;
    if (ctl.tick) begin
      if (roff_r != '0) begin
        roff_nxt = roff_r - TB'(1);
        if (roff_r == TB'(1)) begin
          drv_nxt = 1'b0;
        end
      end
      cyc_nxt  = (cyc_r != '0) ? cyc_r - TB'(1) : '0;
      fsol_nxt = (fsol_r != '0) ? fsol_r - TB'(1) : '0;
      prev_nxt = st_r;
      case (st_r)
        SM_INIT: begin
          st_nxt = SM_WAIT;
        end
        SM_WAIT: begin
          if (entry) begin
            cyc_nxt = TB'(SOLAR_WAIT_MS);
          end
          if (cyc_nxt == '0) begin
            st_nxt = SM_RUN;
          end
        end
        SM_RUN: begin
          if (cyc_nxt == '0) begin
            cyc_nxt = TB'(period_ms);
            drv_nxt = 1'b1;
            if (on_ms != '0) begin
              roff_nxt = TB'(on_ms);
            end
          end
          // The run state falls into the night checks; together they
          // reduce to this priority order.
          if (fsol_nxt != '0) begin
            st_nxt = SM_FORCE;
          end else if (ctl.night) begin
            st_nxt = SM_NIGHT;
          end else begin
            st_nxt = SM_RUN;
          end
        end
        SM_NIGHT: begin
          // Night mode leaves the relay as it is.
          if (fsol_nxt != '0) begin
            st_nxt = SM_FORCE;
          end else if (!ctl.night) begin
            st_nxt = SM_RUN;
          end
        end
        SM_FORCE: begin
          if (entry) begin
            drv_nxt = 1'b1;
          end
          // The auto-off countdown tracks the force countdown every tick.
          roff_nxt = fsol_nxt;
          if (fsol_nxt == '0) begin
            drv_nxt = 1'b0;
            if (ctl.night) begin
              st_nxt = SM_NIGHT;
            end else begin
              st_nxt  = SM_RUN;
              cyc_nxt = TB'(SOLAR_FALLBACK_MS);
            end
          end
        end
        default: begin
        end
      endcase
    end else if (ctl.force_solar) begin
      fsol_nxt = TB'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SM_INIT;
      prev_r <= SM_INIT;
      cyc_r  <= '0;
      fsol_r <= '0;
      roff_r <= '0;
      drv_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      prev_r <= prev_nxt;
      cyc_r  <= cyc_nxt;
      fsol_r <= fsol_nxt;
      roff_r <= roff_nxt;
      drv_r  <= drv_nxt;
    end
  end

  assign relay_nxt = drv_nxt;
  assign mode_nxt  = st_nxt;

endmodule

FILE: rtl/pump_schedule_timer.sv
// An accepted item is held in the input register, then applied, and its result is registered
// in the output register until taken. Throughput: one item per cycle while no result waits
// there untaken; the counters and both pump machines update their state registers once per
// item, so items follow back to back.
// Reset: rst_n is synchronous and active low; it loads the default configuration, the
// 09:00 time of day, day mode, both machines in init and both relays off.
module pump_schedule_timer import pst_pkg::*; #(
  parameter int TIMER_BITS = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  pst_in_if.sink               in_ch,
  pst_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] filter_on_r, filter_period_r, solar_on_r, solar_period_r;
  logic [CFG_W-1:0] day_start_r, night_start_r;

  logic             s1_valid_r;
  logic [REQ_W-1:0] s1_req_r;
  logic [CFG_W-1:0] s1_value_r;
  logic             s1_go;

  logic              out_valid_r;
  logic              out_filter_relay_r, out_solar_relay_r, out_night_r;
  logic [TOD_W-1:0]  out_tod_r;
  logic [MODE_W-1:0] out_filter_mode_r, out_solar_mode_r;

  logic              tick, set_time, force_off, force_on, force_solar;
  logic              night_nxt;
  logic [TOD_W-1:0]  tod_nxt;
  logic              filter_relay_nxt, solar_relay_nxt;
  logic [MODE_W-1:0] filter_mode_nxt, solar_mode_nxt;
  pst_ctl_t          ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_on_r     <= RST_FILTER_ON_MS;
      filter_period_r <= RST_FILTER_PERIOD_MS;
      solar_on_r      <= RST_SOLAR_ON_MS;
      solar_period_r  <= RST_SOLAR_PERIOD_MS;
      day_start_r     <= RST_DAY_START_MS;
      night_start_r   <= RST_NIGHT_START_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FILTER_ON:     filter_on_r     <= cfg_wdata;
        CFG_FILTER_PERIOD: filter_period_r <= cfg_wdata;
        CFG_SOLAR_ON:      solar_on_r      <= cfg_wdata;
        CFG_SOLAR_PERIOD:  solar_period_r  <= cfg_wdata;
        CFG_DAY_START:     day_start_r     <= cfg_wdata;
        CFG_NIGHT_START:   night_start_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // The input stage moves on whenever the output register is free or being emptied.
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req_r   <= in_ch.req_type;
      s1_value_r <= in_ch.value;
    end
  end

  always_comb begin
    tick        = 1'b0;
    set_time    = 1'b0;
    force_off   = 1'b0;
    force_on    = 1'b0;
    force_solar = 1'b0;
    case (s1_req_r)
      REQ_TICK:        tick        = s1_go;
      REQ_SET_TIME:    set_time    = s1_go;
      REQ_FORCE_OFF:   force_off   = s1_go;
      REQ_FORCE_ON:    force_on    = s1_go;
      REQ_FORCE_SOLAR: force_solar = s1_go;
      default: begin
      end
    endcase
  end

  pst_clock u_clock (
    .clk           (clk),
    .rst_n         (rst_n),
    .tick          (tick),
    .set_time      (set_time),
    .value         (s1_value_r),
    .day_start_ms  (day_start_r),
    .night_start_ms(night_start_r),
    .night_nxt     (night_nxt),
    .tod_nxt       (tod_nxt)
  );

  assign ctl = '{tick: tick, force_off: force_off, force_on: force_on,
                 force_solar: force_solar, night: night_nxt};

  pst_filter #(.TIMER_BITS(TIMER_BITS)) u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .value    (s1_value_r),
    .on_ms    (filter_on_r),
    .period_ms(filter_period_r),
    .relay_nxt(filter_relay_nxt),
    .mode_nxt (filter_mode_nxt)
  );

  pst_solar #(.TIMER_BITS(TIMER_BITS)) u_solar (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .value    (s1_value_r),
    .on_ms    (solar_on_r),
    .period_ms(solar_period_r),
    .relay_nxt(solar_relay_nxt),
    .mode_nxt (solar_mode_nxt)
  );

  // Output register: a snapshot of the state right after the item was applied.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_filter_relay_r <= filter_relay_nxt;
      out_solar_relay_r  <= solar_relay_nxt;
      out_night_r        <= night_nxt;
      out_tod_r          <= tod_nxt;
      out_filter_mode_r  <= filter_mode_nxt;
      out_solar_mode_r   <= solar_mode_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filter_relay   = out_filter_relay_r;
  assign out_ch.solar_relay    = out_solar_relay_r;
  assign out_ch.night_flag     = out_night_r;
  assign out_ch.time_of_day_ms = out_tod_r;
  assign out_ch.filter_mode    = out_filter_mode_r;
  assign out_ch.solar_mode     = out_solar_mode_r;

`ifndef SYNTHESIS
  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("item left the input stage without reaching the output register");

  a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked item");

  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> (out_tod_r == $past(tod_nxt)) && (out_night_r == $past(night_nxt)))
    else $error("result does not match the clock state after the item");
`endif

endmodule

FILE: bench/pump_schedule_timer_test.sv
`timescale 1ns / 1ps

import pst_pkg::*;

typedef struct packed {
  logic              filter_relay;
  logic              solar_relay;
  logic              night_flag;
  logic [TOD_W-1:0]  time_of_day_ms;
  logic [MODE_W-1:0] filter_mode;
  logic [MODE_W-1:0] solar_mode;
} pump_status_t;

// Tracks the relay schedule item by item and holds the status words still to come.
class schedule_tracker;
  int unsigned filter_on, filter_period, solar_on, solar_period, day_start, night_start;
  int unsigned tod, filter_left, solar_left, off_force, on_force, solar_force;
  int unsigned relay_left[2];
  bit relay_on[2];
  bit night;
  bit [MODE_W-1:0] fstate, fprev, sstate, sprev;
  pump_status_t status_due[$];
  int errors;

  function new();
    filter_on = RST_FILTER_ON_MS;
    filter_period = RST_FILTER_PERIOD_MS;
    solar_on = RST_SOLAR_ON_MS;
    solar_period = RST_SOLAR_PERIOD_MS;
    day_start = RST_DAY_START_MS;
    night_start = RST_NIGHT_START_MS;
    tod = RST_TOD_MS;
    night = 1'b0;
    fstate = FM_INIT;
    fprev = FM_INIT;
    sstate = SM_INIT;
    sprev = SM_INIT;
    filter_left = 0;
    solar_left = 0;
    off_force = 0;
    on_force = 0;
    solar_force = 0;
    relay_left[0] = 0;
    relay_left[1] = 0;
    relay_on[0] = 1'b0;
    relay_on[1] = 1'b0;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      CFG_FILTER_ON:     filter_on = val;
      CFG_FILTER_PERIOD: filter_period = val;
      CFG_SOLAR_ON:      solar_on = val;
      CFG_SOLAR_PERIOD:  solar_period = val;
      CFG_DAY_START:     day_start = val;
      CFG_NIGHT_START:   night_start = val;
      default: ;
    endcase
  endfunction

  function int pending();
    return status_due.size();
  endfunction

  // A zero span leaves the auto-off countdown as it was.
  function void set_relay(int r, bit on, int unsigned span);
    relay_on[r] = on;
    if (on && span != 0) relay_left[r] = span;
  endfunction

  function void advance_clock();
    tod = tod + 1;
    if (tod >= DAY_MS) tod = 0;
    if (!night && tod == night_start) night = 1'b1;
    else if (night && tod == day_start) night = 1'b0;
    for (int r = 0; r < 2; r++) begin
      if (relay_left[r] != 0) begin
        relay_left[r]--;
        if (relay_left[r] == 0) relay_on[r] = 1'b0;
      end
    end
    if (filter_left != 0) filter_left--;
    if (solar_left != 0) solar_left--;
    if (solar_force != 0) solar_force--;
    if (off_force != 0) off_force--;
    if (on_force != 0) on_force--;
  endfunction

  function void step_filter();
    bit entry;
    entry = (fstate != fprev);
    fprev = fstate;
    case (fstate)
      FM_INIT: fstate = FM_WAIT;
      FM_WAIT: begin
        if (entry) filter_left = FILTER_WAIT_MS;
        if (filter_left == 0) fstate = FM_RUN;
      end
      FM_RUN: begin
        if (entry) filter_left = 0;
        if (filter_left == 0) begin
          filter_left = filter_period;
          set_relay(0, 1'b1, filter_on);
        end
        if (off_force != 0) fstate = FM_FOFF;
        else if (on_force != 0) fstate = FM_FON;
        else if (night) fstate = FM_NIGHT;
      end
      FM_NIGHT: begin
        if (entry) set_relay(0, 1'b0, 0);
        if (off_force != 0) fstate = FM_FOFF;
        else if (on_force != 0) fstate = FM_FON;
        else if (!night) fstate = FM_RUN;
      end
      FM_FON: begin
        if (entry) set_relay(0, 1'b1, on_force);
        if (on_force == 0) fstate = night ? FM_NIGHT : FM_RUN;
      end
      FM_FOFF: begin
        if (entry) set_relay(0, 1'b0, 0);
        if (off_force == 0) fstate = night ? FM_NIGHT : FM_RUN;
      end
      default: ;
    endcase
  endfunction

  function void solar_resume();
    if (solar_force != 0) sstate = SM_FORCE;
    else if (!night) sstate = SM_RUN;
  endfunction

  function void step_solar();
    bit entry;
    entry = (sstate != sprev);
    sprev = sstate;
    case (sstate)
      SM_INIT: sstate = SM_WAIT;
      SM_WAIT: begin
        if (entry) solar_left = SOLAR_WAIT_MS;
        if (solar_left == 0) sstate = SM_RUN;
      end
      // The run state falls through into the night checks in the same tick.
      SM_RUN: begin
        if (solar_left == 0) begin
          solar_left = solar_period;
          set_relay(1, 1'b1, solar_on);
        end
        if (solar_force != 0) sstate = SM_FORCE;
        else if (night) sstate = SM_NIGHT;
        solar_resume();
      end
      SM_NIGHT: solar_resume();
      SM_FORCE: begin
        if (entry) set_relay(1, 1'b1, solar_force);
        relay_left[1] = solar_force;
        if (solar_force == 0) begin
          set_relay(1, 1'b0, 0);
          sstate = night ? SM_NIGHT : SM_RUN;
          if (sstate == SM_RUN) solar_left = SOLAR_FALLBACK_MS;
        end
      end
      default: ;
    endcase
  endfunction

  function void note_request(logic [REQ_W-1:0] req, logic [CFG_W-1:0] val);
    pump_status_t want;
    case (req)
      REQ_TICK: begin
        advance_clock();
        step_filter();
        step_solar();
      end
      REQ_SET_TIME: begin
        tod = val;
        night = (val < day_start) || (val > night_start);
      end
      REQ_FORCE_OFF: begin
        off_force = val;
        on_force = 0;
      end
      REQ_FORCE_ON: begin
        on_force = val;
        off_force = 0;
      end
      REQ_FORCE_SOLAR: solar_force = val;
      default: ;
    endcase
    want.filter_relay = relay_on[0];
    want.solar_relay = relay_on[1];
    want.night_flag = night;
    want.time_of_day_ms = tod[TOD_W-1:0];
    want.filter_mode = fstate;
    want.solar_mode = sstate;
    status_due.push_back(want);
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
    end
  endfunction

  function void check_status(pump_status_t got);
    pump_status_t want;
    if (status_due.size() == 0) begin
      errors++;
      $display("%0t: status word arrived with no item outstanding", $time);
      return;
    end
    want = status_due.pop_front();
    compare("filter_relay", want.filter_relay, got.filter_relay);
    compare("solar_relay", want.solar_relay, got.solar_relay);
    compare("night_flag", want.night_flag, got.night_flag);
    compare("time_of_day_ms", want.time_of_day_ms, got.time_of_day_ms);
    compare("filter_mode", want.filter_mode, got.filter_mode);
    compare("solar_mode", want.solar_mode, got.solar_mode);
  endfunction
endclass

module pump_schedule_timer_test;
  localparam logic [CFG_W-1:0] VALUE_ALL_ONES = '1;
  localparam logic [CFG_W-1:0] LAST_MS_OF_DAY = CFG_W'(DAY_MS - 1);
  localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = REQ_FORCE_SOLAR + 1'b1;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LAST = '1;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  bit no_gaps = 1'b0;
  bit stall_out = 1'b0;
  schedule_tracker sb = new();

  pst_in_if in_ch();
  pst_out_if out_ch();

  pump_schedule_timer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  task automatic send_item(input logic [REQ_W-1:0] req, input logic [CFG_W-1:0] val);
    if (!no_gaps && $urandom_range(99) < 33) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.value <= val;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_request(req, val);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(input logic [CFG_W-1:0] f_on, input logic [CFG_W-1:0] f_per,
                           input logic [CFG_W-1:0] s_on, input logic [CFG_W-1:0] s_per,
                           input logic [CFG_W-1:0] day, input logic [CFG_W-1:0] dusk);
    wait_drained();
    write_reg(CFG_FILTER_ON, f_on);
    write_reg(CFG_FILTER_PERIOD, f_per);
    write_reg(CFG_SOLAR_ON, s_on);
    write_reg(CFG_SOLAR_PERIOD, s_per);
    write_reg(CFG_DAY_START, day);
    write_reg(CFG_NIGHT_START, dusk);
    cfg_we <= 1'b0;
  endtask

  // Mostly 6 ms before to 2 ms past a day, night or midnight boundary, so ticks cross it.
  function automatic logic [CFG_W-1:0] pick_time();
    longint t;
    int unsigned r;
    r = $urandom_range(99);
    if (r >= 90) return CFG_W'($urandom());
    if (r < 40) t = sb.day_start;
    else if (r < 80) t = sb.night_start;
    else t = DAY_MS;
    t = t - longint'($urandom_range(8)) + 2;
    if (t < 0) t = 0;
    if (t > longint'(VALUE_ALL_ONES)) t = VALUE_ALL_ONES;
    return CFG_W'(t);
  endfunction

  function automatic logic [CFG_W-1:0] pick_span();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) return CFG_W'($urandom_range(40));
    if (r < 95) return CFG_W'($urandom_range(400));
    return CFG_W'($urandom());
  endfunction

  task automatic run_phase(input int count, input int tick_pct, input int drain_at,
                           input int calm_from, input int calm_to);
    int unsigned k;
    for (int i = 0; i < count; i++) begin
      no_gaps = (i >= calm_from) && (i < calm_to);
      if (i == drain_at) wait_drained();
      if ($urandom_range(99) < tick_pct) begin
        send_item(REQ_TICK, CFG_W'($urandom()));
      end else begin
        k = $urandom_range(19);
        if (k < 5) send_item(REQ_SET_TIME, pick_time());
        else if (k < 9) send_item(REQ_FORCE_OFF, pick_span());
        else if (k < 13) send_item(REQ_FORCE_ON, pick_span());
        else if (k < 17) send_item(REQ_FORCE_SOLAR, pick_span());
        else send_item(REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST)),
                       CFG_W'($urandom()));
      end
    end
    no_gaps = 1'b0;
  endtask

  // Result side: checks each status word and paces ready, with one long hold-off.
  initial begin
    pump_status_t got;
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.filter_relay = out_ch.filter_relay;
        got.solar_relay = out_ch.solar_relay;
        got.night_flag = out_ch.night_flag;
        got.time_of_day_ms = out_ch.time_of_day_ms;
        got.filter_mode = out_ch.filter_mode;
        got.solar_mode = out_ch.solar_mode;
        sb.check_status(got);
      end
      if (hold_left != 0) begin
        hold_left--;
      end else if (stall_out && !hold_done) begin
        hold_left = RX_HOLD_CYCLES;
        hold_done = 1'b1;
      end
      out_ch.ready <= (hold_left == 0) && (no_gaps || $urandom_range(99) >= 33);
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("pump_schedule_timer_test: done, errors");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.value = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_FILTER_ON;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items on reset configuration: wrap-around, both boundaries, forces, unused codes.
    send_item(REQ_TICK, '0);
    send_item(REQ_SET_TIME, '0);
    send_item(REQ_TICK, VALUE_ALL_ONES);
    send_item(REQ_SET_TIME, VALUE_ALL_ONES);
    send_item(REQ_TICK, '0);
    send_item(REQ_SET_TIME, LAST_MS_OF_DAY);
    send_item(REQ_TICK, '0);
    send_item(REQ_SET_TIME, RST_DAY_START_MS - 1'b1);
    send_item(REQ_TICK, '0);
    send_item(REQ_SET_TIME, RST_NIGHT_START_MS);
    send_item(REQ_SET_TIME, RST_NIGHT_START_MS - 1'b1);
    send_item(REQ_TICK, '0);
    send_item(REQ_TICK, '0);
    send_item(REQ_SET_TIME, RST_DAY_START_MS);
    send_item(REQ_FORCE_OFF, VALUE_ALL_ONES);
    send_item(REQ_FORCE_ON, '0);
    send_item(REQ_FORCE_ON, VALUE_ALL_ONES);
    send_item(REQ_FORCE_SOLAR, VALUE_ALL_ONES);
    send_item(REQ_FORCE_SOLAR, '0);
    send_item(REQ_UNUSED_FIRST, VALUE_ALL_ONES);
    send_item(REQ_UNUSED_FIRST + 1'b1, '0);
    send_item(REQ_UNUSED_LAST, CFG_W'($urandom()));
    send_item(REQ_FORCE_OFF, '0);
    send_item(REQ_TICK, '0);

    // The solar machine waits 1000 ticks before its first run, so this phase is tick heavy.
    configure(CFG_W'($urandom_range(1, 30)), CFG_W'($urandom_range(1, 60)),
              CFG_W'($urandom_range(1, 20)), CFG_W'($urandom_range(1, 40)),
              CFG_W'($urandom_range(DAY_MS - 1)), CFG_W'($urandom_range(DAY_MS - 1)));
    run_phase(1100, 96, -1, 400, 700);

    configure(VALUE_ALL_ONES, '0, '0, VALUE_ALL_ONES, '0, LAST_MS_OF_DAY);
    run_phase(250, 80, 120, -1, -1);

    configure(CFG_W'($urandom_range(30)), CFG_W'($urandom_range(60)),
              CFG_W'($urandom_range(20)), CFG_W'($urandom_range(40)),
              CFG_W'($urandom_range(DAY_MS - 1)), CFG_W'($urandom_range(DAY_MS - 1)));
    stall_out = 1'b1;
    run_phase(180, 80, -1, -1, -1);

    configure('0, VALUE_ALL_ONES, VALUE_ALL_ONES, '0, LAST_MS_OF_DAY, '0);
    run_phase(100, 80, -1, -1, -1);

    wait_drained();
    repeat (6) @(posedge clk);
    if (sb.errors == 0)
      $display("pump_schedule_timer_test: done, clean");
    else
      $display("pump_schedule_timer_test: done, errors");
    $finish;
  end
endmodule
